// ----- rtl/sssc_pkg.sv -----
package sssc_pkg;

    localparam int DEFAULT_NUM_DIGITS = 3;

    localparam logic [7:0]  FRAME_START        = 8'd255;
    localparam logic [3:0]  DIGIT_MAX          = 4'd9;
    localparam logic [15:0] ADC_START_TICK_RST = 16'd64;
    localparam logic [15:0] REPORT_TICK_RST    = 16'd128;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ADC_START_TICK = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_TICK    = 1'b1;

    localparam logic [7:0] LED_CODE_ONE = 8'd1;
    localparam logic [7:0] LED_CODE_TWO = 8'd2;

    typedef enum logic [1:0] {
        FUNC_BYTE   = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_SAMPLE = 2'd2
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  rx_byte;
        logic [11:0] sample;
    } item_t;

    typedef struct packed {
        logic [2:0] digit_select;
        logic [6:0] segments;
        logic       dot_level;
        logic [2:0] led_select;
        logic       adc_start;
        logic       tx_valid;
        logic [7:0] tx_low;
        logic [3:0] tx_high;
    } result_t;

    // lit segments, A in bit 0 through G in bit 6
    function automatic logic [6:0] lit_mask(input logic [3:0] code);
        logic [6:0] mask;
        case (code)
            4'd0:    mask = 7'h3F;
            4'd1:    mask = 7'h06;
            4'd2:    mask = 7'h5B;
            4'd3:    mask = 7'h4F;
            4'd4:    mask = 7'h66;
            4'd5:    mask = 7'h6D;
            4'd6:    mask = 7'h7D;
            4'd7:    mask = 7'h07;
            4'd8:    mask = 7'h7F;
            default: mask = 7'h6F;
        endcase
        return mask;
    endfunction

    function automatic logic [2:0] led_for(input logic [7:0] code);
        logic [2:0] pins;
        if (code == LED_CODE_ONE)
        begin
            pins = 3'b010;
        end
        else if (code == LED_CODE_TWO)
        begin
            pins = 3'b001;
        end
        else
        begin
            pins = 3'b100;
        end
        return pins;
    endfunction

endpackage

// ----- rtl/sssc_in_stage.sv -----
module sssc_in_stage
    import sssc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  advance,
    output logic  stage_valid,
    output item_t stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ----- rtl/sssc_core.sv -----
module sssc_core
    import sssc_pkg::*;
#(
    parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   fire,
    input  item_t                  item,
    output result_t                res
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int FP_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);
    localparam logic [FP_W-1:0]  FP_MAX   = FP_W'(NUM_DIGITS);

    logic [15:0]      adc_start_tick_reg;
    logic [15:0]      report_tick_reg;
    logic [FP_W-1:0]  frame_pos_reg;
    logic [FP_W-1:0]  frame_pos_next;
    logic [3:0]       digit_reg [NUM_DIGITS];
    logic [IDX_W-1:0] scan_reg;
    logic [IDX_W-1:0] scan_next;
    logic [15:0]      tick_reg;
    logic [15:0]      tick_next;
    logic [11:0]      sample_reg;
    logic [2:0]       led_reg;
    logic [2:0]       led_next;
    logic [2:0]       select_reg;
    logic [2:0]       select_next;
    logic [6:0]       seg_reg;
    logic [6:0]       seg_next;
    logic             dot_reg;
    logic             dot_next;

    logic             digit_we;
    logic [FP_W-1:0]  digit_pos;
    logic [IDX_W-1:0] digit_idx;
    logic [3:0]       digit_val;
    logic [IDX_W-1:0] shown;
    logic [7:0]       shown_onehot;
    logic [15:0]      tick_inc;
    logic             hit_start;
    logic             hit_report;

    assign shown        = (scan_reg == LAST_IDX) ? '0 : scan_reg + IDX_W'(1);
    assign shown_onehot = 8'd1 << shown;
    assign tick_inc     = tick_reg + 16'd1;
    assign hit_start    = (tick_inc == adc_start_tick_reg);
    assign hit_report   = (tick_inc == report_tick_reg);
    assign digit_pos    = frame_pos_reg - FP_W'(1);
    assign digit_idx    = digit_pos[IDX_W-1:0];
    assign digit_val    = (item.rx_byte > 8'(DIGIT_MAX)) ? DIGIT_MAX : item.rx_byte[3:0];

    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        led_next       = led_reg;
        digit_we       = 1'b0;
        scan_next      = scan_reg;
        tick_next      = tick_reg;
        select_next    = select_reg;
        seg_next       = seg_reg;
        dot_next       = dot_reg;
        res.adc_start  = 1'b0;
        res.tx_valid   = 1'b0;
        res.tx_low     = 8'd0;
        res.tx_high    = 4'd0;
        case (item.func)
            FUNC_BYTE:
            begin
                if (item.rx_byte == FRAME_START)
                begin
                    frame_pos_next = '0;
                end
                else
                begin
                    if (frame_pos_reg == '0)
                    begin
                        led_next = led_for(item.rx_byte);
                    end
                    else
                    begin
                        digit_we = 1'b1;
                    end
                    if (frame_pos_reg != FP_MAX)
                    begin
                        frame_pos_next = frame_pos_reg + FP_W'(1);
                    end
                end
            end
            FUNC_TICK:
            begin
                select_next   = shown_onehot[2:0];
                seg_next      = ~lit_mask(digit_reg[shown]);
                dot_next      = (shown != IDX_W'(1)) || (NUM_DIGITS == 1);
                scan_next     = shown;
                res.adc_start = hit_start;
                tick_next     = tick_inc;
                if (hit_report)
                begin
                    res.tx_valid = 1'b1;
                    res.tx_low   = sample_reg[7:0];
                    res.tx_high  = sample_reg[11:8];
                    tick_next    = 16'd0;
                end
            end
            default:
            begin
            end
        endcase
        res.digit_select = select_next;
        res.segments     = seg_next;
        res.dot_level    = dot_next;
        res.led_select   = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_start_tick_reg <= ADC_START_TICK_RST;
            report_tick_reg    <= REPORT_TICK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ADC_START_TICK: adc_start_tick_reg <= cfg_data;
                CFG_REPORT_TICK:    report_tick_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= '0;
            scan_reg      <= '0;
            tick_reg      <= 16'd0;
            sample_reg    <= 12'd0;
            led_reg       <= 3'd0;
            select_reg    <= 3'd0;
            seg_reg       <= 7'd0;
            dot_reg       <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
        end
        else if (fire)
        begin
            frame_pos_reg <= frame_pos_next;
            scan_reg      <= scan_next;
            tick_reg      <= tick_next;
            led_reg       <= led_next;
            select_reg    <= select_next;
            seg_reg       <= seg_next;
            dot_reg       <= dot_next;
            if (item.func == FUNC_SAMPLE)
            begin
                sample_reg <= item.sample;
            end
            if (digit_we)
            begin
                digit_reg[digit_idx] <= digit_val;
            end
        end
    end

endmodule

// ----- rtl/sssc_out_stage.sv -----
module sssc_out_stage
    import sssc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    stage_valid,
    input  result_t res,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/seven_segment_scan_and_command_frame.sv -----
// throughput: one item per cycle while out_stall is low or the output register is empty;
// path is the input register, then state update into the result register
// reset: asynchronous active low; clears pins, digits, frame position, scan, tick count,
// held sample and both stages; tick registers return to 64 and 128
module seven_segment_scan_and_command_frame
    import sssc_pkg::*;
#(
    parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             func,
    input  logic [7:0]             rx_byte,
    input  logic [11:0]            sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             digit_select,
    output logic [6:0]             segments,
    output logic                   dot_level,
    output logic [2:0]             led_select,
    output logic                   adc_start,
    output logic                   tx_valid,
    output logic [7:0]             tx_low,
    output logic [3:0]             tx_high
);

    item_t   in_item;
    item_t   stage_item;
    logic    stage_valid;
    logic    advance;
    result_t res;
    result_t out_res;

    assign in_item.func    = func;
    assign in_item.rx_byte = rx_byte;
    assign in_item.sample  = sample;

    sssc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    sssc_core #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (stage_valid && advance),
        .item      (stage_item),
        .res       (res)
    );

    sssc_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .res         (res),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_res     (out_res)
    );

    assign digit_select = out_res.digit_select;
    assign segments     = out_res.segments;
    assign dot_level    = out_res.dot_level;
    assign led_select   = out_res.led_select;
    assign adc_start    = out_res.adc_start;
    assign tx_valid     = out_res.tx_valid;
    assign tx_low       = out_res.tx_low;
    assign tx_high      = out_res.tx_high;

endmodule
